@@ rtl/core/wcts_pkg.sv @@
package wcts_pkg;

  // screen and texture geometry
  localparam int SCREEN_HEIGHT = 512;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int TEXTURE_SIZE  = 64;
  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int COL_W   = 10;
  localparam int LH_W    = 16;
  localparam int PERP_W  = 24;
  localparam int DIR_W   = 18;
  localparam int PLAY_W  = 24;
  localparam int PROW_W  = 9;
  localparam int TSEL_W  = 2;
  localparam int TEX_W   = $clog2(TEXTURE_SIZE);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
  localparam int STEP_W  = 24;

  // derived widths
  localparam int HIT_W   = 2 * FRACTION_BITS;
  localparam int POS_W   = TEX_W + FRACTION_BITS;
  localparam int DIV_W   = TEX_W + FRACTION_BITS + 1;
  localparam int CNT_W   = $clog2(DIV_W);

  typedef struct packed {
    logic start;
    logic hit;
    logic div_step;
    logic finish;
    logic pixel;
  } cmd_t;

  typedef struct packed {
    logic lh_zero;
    logic span_active;
  } sts_t;

endpackage

@@ rtl/core/wcts_ctrl.sv @@
module wcts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_mode_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wcts_pkg::sts_t sts_i,
  output wcts_pkg::cmd_t cmd_o
);
  import wcts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_DIV,
    ST_POS
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    accept     = in_valid_i && in_ready_o;

    cmd_o          = '0;
    cmd_o.start    = accept && !in_mode_i;
    cmd_o.pixel    = accept && in_mode_i && sts_i.span_active;
    cmd_o.hit      = (state_q == ST_HIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_POS);

    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_HIT;
        end
      end
      ST_HIT: begin
        cnt_d = '0;
        // no division for a zero line height
        if (sts_i.lh_zero) begin
          state_d = ST_POS;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.pixel) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/wcts_datapath.sv @@
module wcts_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wcts_pkg::cmd_t                      cmd_i,
  output wcts_pkg::sts_t                      sts_o,
  input  logic [wcts_pkg::COL_W-1:0]          column_x_i,
  input  logic [wcts_pkg::LH_W-1:0]           line_height_i,
  input  logic                                hit_side_i,
  input  logic [wcts_pkg::PERP_W-1:0]         perp_distance_i,
  input  logic signed [wcts_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [wcts_pkg::DIR_W-1:0]   dir_y_i,
  input  logic [wcts_pkg::PLAY_W-1:0]         player_x_i,
  input  logic [wcts_pkg::PLAY_W-1:0]         player_y_i,
  input  logic                                x_step_positive_i,
  input  logic                                y_step_positive_i,
  output logic [wcts_pkg::COL_W-1:0]          pixel_column_o,
  output logic [wcts_pkg::PROW_W-1:0]         pixel_row_o,
  output logic [wcts_pkg::TSEL_W-1:0]         texture_select_o,
  output logic [wcts_pkg::TEX_W-1:0]          texel_u_o,
  output logic [wcts_pkg::TEX_W-1:0]          texel_v_o,
  output logic                                last_o
);
  import wcts_pkg::*;

  localparam int HALF_H = SCREEN_HEIGHT / 2;
  localparam int QX_W   = (DIV_W > STEP_W) ? DIV_W : STEP_W;
  localparam int MUL_W  = PERP_W + 1 + DIR_W;

  // span registers
  logic                     active_q;
  logic [COL_W-1:0]         col_q;
  logic [ROW_W-1:0]         row_q;
  logic [ROW_W-1:0]         end_q;
  logic [TEX_W-1:0]         u_q;
  logic [TSEL_W-1:0]        tsel_q;
  logic [POS_W-1:0]         pos_q;
  logic [STEP_W-1:0]        step_q;

  // setup registers
  logic [LH_W-1:0]          lh_q;
  logic [LH_W-1:0]          offset_q;
  logic [HIT_W-1:0]         prod_q;
  logic [FRACTION_BITS-1:0] pfrac_q;
  logic                     flip_q;
  logic [LH_W-1:0]          rem_q;
  logic [DIV_W-1:0]         quot_q;
  logic [DIV_W-1:0]         dvd_q;

  // result registers
  logic [COL_W-1:0]         o_col_q;
  logic [ROW_W-1:0]         o_row_q;
  logic [TSEL_W-1:0]        o_tsel_q;
  logic [TEX_W-1:0]         o_u_q;
  logic [TEX_W-1:0]         o_v_q;
  logic                     o_last_q;

  logic [LH_W-1:0]          half;
  logic                     big;
  logic [LH_W-1:0]          end_sum;
  logic [ROW_W-1:0]         start_row;
  logic [ROW_W-1:0]         end_row;
  logic [LH_W-1:0]          offset;
  logic                     span_ok;
  logic signed [PERP_W:0]   perp_s;
  logic signed [DIR_W-1:0]  dir_sel;
  logic signed [MUL_W-1:0]  prod_full;
  logic [HIT_W-1:0]         hit;
  logic [TEX_W-1:0]         u_raw;
  logic [LH_W:0]            rem_sh;
  logic                     ge;
  logic [LH_W:0]            rem_sub;
  logic [QX_W-1:0]          q_ext;
  logic [STEP_W-1:0]        step_sat;
  logic [ROW_W:0]           row_next;
  logic                     is_last;

  always_comb begin
    half      = {1'b0, line_height_i[LH_W-1:1]};
    big       = half >= LH_W'(HALF_H);
    start_row = big ? '0 : ROW_W'(LH_W'(HALF_H) - half);
    end_sum   = half + LH_W'(HALF_H);
    end_row   = (end_sum >= LH_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                   : ROW_W'(end_sum);
    // rows skipped above the screen top
    offset    = big ? (half - LH_W'(HALF_H)) : '0;
    span_ok   = (line_height_i != '0) && (start_row < end_row) &&
                (32'(column_x_i) < 32'(SCREEN_WIDTH));

    perp_s    = $signed({1'b0, perp_distance_i});
    dir_sel   = hit_side_i ? dir_x_i : dir_y_i;
    prod_full = perp_s * dir_sel;

    // only the fraction of the hit point matters
    hit       = {pfrac_q, {FRACTION_BITS{1'b0}}} + prod_q;
    u_raw     = hit[HIT_W-1 -: TEX_W];

    rem_sh    = {rem_q, dvd_q[DIV_W-1]};
    ge        = rem_sh >= {1'b0, lh_q};
    rem_sub   = rem_sh - {1'b0, lh_q};

    q_ext     = QX_W'(quot_q);
    step_sat  = (q_ext > QX_W'((64'd1 << STEP_W) - 64'd1)) ? '1 : STEP_W'(q_ext);

    row_next  = {1'b0, row_q} + (ROW_W+1)'(1);
    is_last   = row_next >= {1'b0, end_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (cmd_i.start) begin
      active_q <= span_ok;
    end else if (cmd_i.pixel && is_last) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q    <= column_x_i;
      row_q    <= start_row;
      end_q    <= end_row;
      tsel_q   <= hit_side_i ? {1'b1, ~y_step_positive_i} : {1'b0, ~x_step_positive_i};
      lh_q     <= line_height_i;
      offset_q <= offset;
      prod_q   <= prod_full[HIT_W-1:0];
      pfrac_q  <= hit_side_i ? player_x_i[FRACTION_BITS-1:0]
                             : player_y_i[FRACTION_BITS-1:0];
      flip_q   <= hit_side_i ? dir_y_i[DIR_W-1]
                             : (!dir_x_i[DIR_W-1] && (dir_x_i != '0));
      rem_q    <= '0;
      quot_q   <= '0;
      dvd_q    <= {1'b1, {(DIV_W-1){1'b0}}};
    end
    if (cmd_i.hit) begin
      u_q <= flip_q ? ~u_raw : u_raw;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? LH_W'(rem_sub) : LH_W'(rem_sh);
      quot_q <= {quot_q[DIV_W-2:0], ge};
      dvd_q  <= dvd_q << 1;
    end
    if (cmd_i.finish) begin
      step_q <= step_sat;
      pos_q  <= POS_W'(offset_q * step_sat);
    end
    if (cmd_i.pixel) begin
      o_col_q  <= col_q;
      o_row_q  <= row_q;
      o_tsel_q <= tsel_q;
      o_u_q    <= u_q;
      o_v_q    <= pos_q[FRACTION_BITS +: TEX_W];
      o_last_q <= is_last;
      pos_q    <= pos_q + POS_W'(step_q);
      row_q    <= ROW_W'(row_next);
    end
  end

  assign sts_o.lh_zero     = (lh_q == '0);
  assign sts_o.span_active = active_q;

  assign pixel_column_o   = o_col_q;
  assign pixel_row_o      = PROW_W'(o_row_q);
  assign texture_select_o = o_tsel_q;
  assign texel_u_o        = o_u_q;
  assign texel_v_o        = o_v_q;
  assign last_o           = o_last_q;

endmodule

@@ rtl/core/wall_column_texture_span.sv @@
// channel   direction  tuser  tlast  tdata
// s_axis    in         mode   -      column_x .. y_step_positive, 144 bits
// m_axis    out        -      last   pixel_column .. texel_v, 40 bits
//
// next-pixel items follow at one per cycle while the output drains
// and each result is valid the cycle after acceptance
// a begin-column item holds off input after acceptance: hit fraction, 23 restoring
// divider steps for the texture step, start-position multiply (no divide at height 0)
// reset clears the controller and the span-active flag; a stalled output keeps its item
// and input waits until the output register is free
module wall_column_texture_span (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // column_x, line_height, hit_side, perp_distance, dir_x, dir_y,
  // player_x, player_y, x_step_positive, y_step_positive, zero fill
  input  logic [143:0] s_axis_tdata_i,
  // mode
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pixel_column, pixel_row, texture_select, texel_u, texel_v, zero fill
  output logic [39:0]  m_axis_tdata_o,
  // last
  output logic         m_axis_tlast_o
);
  import wcts_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  logic [COL_W-1:0]        pix_col;
  logic [PROW_W-1:0]       pix_row;
  logic [TSEL_W-1:0]       tsel;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;

  wcts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_mode_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wcts_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .column_x_i        (s_axis_tdata_i[9:0]),
    .line_height_i     (s_axis_tdata_i[25:10]),
    .hit_side_i        (s_axis_tdata_i[26]),
    .perp_distance_i   (s_axis_tdata_i[50:27]),
    .dir_x_i           ($signed(s_axis_tdata_i[68:51])),
    .dir_y_i           ($signed(s_axis_tdata_i[86:69])),
    .player_x_i        (s_axis_tdata_i[110:87]),
    .player_y_i        (s_axis_tdata_i[134:111]),
    .x_step_positive_i (s_axis_tdata_i[135]),
    .y_step_positive_i (s_axis_tdata_i[136]),
    .pixel_column_o    (pix_col),
    .pixel_row_o       (pix_row),
    .texture_select_o  (tsel),
    .texel_u_o         (tex_u),
    .texel_v_o         (tex_v),
    .last_o            (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'b0, tex_v, tex_u, tsel, pix_row, pix_col};

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // column setup blocks input right after a begin item
  a_begin_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("input accepted during column setup");

  // a new result only follows a pixel item
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o ##1 m_axis_tvalid_o) |-> $past(s_acc && s_axis_tuser_i))
    else $error("result without a pixel item");

  // the span closes exactly on the last row
  a_span_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pixel |=> (m_axis_tlast_o == !sts.span_active))
    else $error("span flag disagrees with last row");

endmodule
